// File: sv/mzp_pkg.sv
// Shared types, codes and widths of the grid maze explorer with path map.
// Used by mzp_front, mzp_back and the top level grid_maze_explorer_path_map.
`default_nettype none

package mzp_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_SIDE_DEF  = 9;
  localparam int DIST_BITS_DEF = 8;

  // Fixed widths.
  localparam int CFG_W     = 8;  // widest configuration register
  localparam int SIZE_W    = 4;  // size and column registers
  localparam int MIN_W     = 8;  // min_distance register
  localparam int SIDE_W    = 5;  // effective grid side, up to 15
  localparam int POS_W     = 6;  // internal signed position, -1 .. 15
  localparam int OUT_POS_W = 5;  // position fields on the result port
  localparam int CODE_W    = 3;  // heading, action and symbol fields

  // Configuration register indexes.
  localparam logic [1:0] CFG_SIZE_X    = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y    = 2'd1;
  localparam logic [1:0] CFG_START_COL = 2'd2;
  localparam logic [1:0] CFG_MIN_DIST  = 2'd3;

  // Configuration reset values.
  localparam logic [SIZE_W-1:0] SIZE_X_RST    = 4'd5;
  localparam logic [SIZE_W-1:0] SIZE_Y_RST    = 4'd4;
  localparam logic [SIZE_W-1:0] START_COL_RST = 4'd0;
  localparam logic [MIN_W-1:0]  MIN_DIST_RST  = 8'd22;

  // Commands.
  localparam logic CMD_EXPLORE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // Headings and arrows.
  localparam logic [CODE_W-1:0] H_UP    = 3'd1;
  localparam logic [CODE_W-1:0] H_RIGHT = 3'd2;
  localparam logic [CODE_W-1:0] H_DOWN  = 3'd3;
  localparam logic [CODE_W-1:0] H_LEFT  = 3'd4;

  // Actions.
  localparam logic [CODE_W-1:0] ACT_RIGHT = 3'd0;
  localparam logic [CODE_W-1:0] ACT_FWD   = 3'd1;
  localparam logic [CODE_W-1:0] ACT_LEFT  = 3'd2;
  localparam logic [CODE_W-1:0] ACT_TURN  = 3'd3;
  localparam logic [CODE_W-1:0] ACT_NONE  = 3'd4;

  // Path symbols beyond the arrows.
  localparam logic [CODE_W-1:0] SYM_EMPTY = 3'd0;
  localparam logic [CODE_W-1:0] SYM_END   = 3'd5;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic cmd;
    logic open_r;
    logic open_f;
    logic open_l;
  } item_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  // Grid geometry registers used by the back.
  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] start_col;
  } geom_t;

endpackage

`default_nettype wire

// File: sv/mzp_front.sv
// Front of the maze explorer: compares the three distances against the
// threshold and holds classified items in a two-entry queue.
// Depends on mzp_pkg.
`default_nettype none

module mzp_front #(
  parameter int DIST_BITS = mzp_pkg::DIST_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [mzp_pkg::MIN_W-1:0] min_dist_i,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     cmd_i,
  input  wire logic [DIST_BITS-1:0]     dist_right_i,
  input  wire logic [DIST_BITS-1:0]     dist_front_i,
  input  wire logic [DIST_BITS-1:0]     dist_left_i,
  input  wire logic                     pop_i,
  output mzp_pkg::queue_t               head_o
);

  localparam int CMP_W = (DIST_BITS > mzp_pkg::MIN_W) ? DIST_BITS : mzp_pkg::MIN_W;

  mzp_pkg::item_t       entry_q [2];
  logic [1:0]           count_d, count_q;
  logic                 wr_ptr_q, rd_ptr_q;
  logic                 push;
  mzp_pkg::item_t       item_in;
  logic [CMP_W-1:0]     min_ext;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign min_ext    = CMP_W'(min_dist_i);

  always_comb begin
    item_in.cmd    = cmd_i;
    item_in.open_r = CMP_W'(dist_right_i) > min_ext;
    item_in.open_f = CMP_W'(dist_front_i) > min_ext;
    item_in.open_l = CMP_W'(dist_left_i) > min_ext;
  end

  always_comb begin
    count_d = count_q;
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: sv/mzp_back.sv
// Back of the maze explorer: sequencer that runs explore and read items
// against the arrow memory and drives the result register.
// Depends on mzp_pkg.
`default_nettype none

module mzp_back #(
  parameter int MAX_SIDE = mzp_pkg::MAX_SIDE_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mzp_pkg::geom_t                   geom_i,
  input  wire mzp_pkg::queue_t                  head_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [mzp_pkg::CODE_W-1:0]            action_o,
  output logic [mzp_pkg::CODE_W-1:0]            heading_o,
  output logic signed [mzp_pkg::OUT_POS_W-1:0]  pos_x_o,
  output logic signed [mzp_pkg::OUT_POS_W-1:0]  pos_y_o,
  output logic                                  exited_o,
  output logic [mzp_pkg::CODE_W-1:0]            path_symbol_o,
  output logic                                  path_last_o,
  output logic                                  path_error_o
);

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STEP_W = $clog2(DEPTH + 1);
  localparam int POS_W  = mzp_pkg::POS_W;
  localparam int SIDE_W = mzp_pkg::SIDE_W;
  localparam int CODE_W = mzp_pkg::CODE_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MARK  = 6'b000010,
    S_MOVE  = 6'b000100,
    S_READ  = 6'b001000,
    S_RDATA = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  function automatic logic [SIDE_W-1:0] eff_size(input logic [mzp_pkg::SIZE_W-1:0] v);
    logic [SIDE_W-1:0] w;
    w = SIDE_W'(v);
    if (v == '0) begin
      return SIDE_W'(1);
    end
    if (w > SIDE_W'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end
    return w;
  endfunction

  function automatic logic in_grid(input logic signed [POS_W-1:0] x,
                                   input logic signed [POS_W-1:0] y,
                                   input logic [SIDE_W-1:0] ex,
                                   input logic [SIDE_W-1:0] ey);
    return !x[POS_W-1] && !y[POS_W-1] && (x[SIDE_W-1:0] < ex) && (y[SIDE_W-1:0] < ey);
  endfunction

  // Linear cell address x + y * size_x; only used for cells inside the grid.
  function automatic logic [IDX_W-1:0] cell_idx(input logic signed [POS_W-1:0] x,
                                                input logic signed [POS_W-1:0] y,
                                                input logic [SIDE_W-1:0] ex);
    logic [8:0] prod;
    logic [8:0] sum;
    prod = 9'({5'b0, y[3:0]}) * 9'({4'b0, ex});
    sum  = prod + 9'({5'b0, x[3:0]});
    return IDX_W'(sum);
  endfunction

  function automatic logic [CODE_W-1:0] rot_cw(input logic [CODE_W-1:0] h,
                                              input logic [1:0] n);
    logic [1:0] t;
    t = h[1:0] - 2'd1 + n;
    return CODE_W'({1'b0, t}) + CODE_W'(1);
  endfunction

  function automatic logic signed [POS_W-1:0] step_x(input logic [CODE_W-1:0] h,
                                                     input logic signed [POS_W-1:0] x);
    logic signed [POS_W-1:0] r;
    case (h)
      mzp_pkg::H_RIGHT: r = x + POS_W'(1);
      mzp_pkg::H_LEFT:  r = x - POS_W'(1);
      default:          r = x;
    endcase
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] step_y(input logic [CODE_W-1:0] h,
                                                     input logic signed [POS_W-1:0] y);
    logic signed [POS_W-1:0] r;
    case (h)
      mzp_pkg::H_UP:   r = y + POS_W'(1);
      mzp_pkg::H_DOWN: r = y - POS_W'(1);
      default:         r = y;
    endcase
    return r;
  endfunction

  state_e                   state_q;
  mzp_pkg::item_t           item_q;
  logic [1:0]               mark_q;
  logic signed [POS_W-1:0]  robot_x_q, robot_y_q;
  logic [CODE_W-1:0]        robot_h_q;
  logic                     started_q;
  logic signed [POS_W-1:0]  cur_x_q, cur_y_q;
  logic                     active_q;
  logic [STEP_W-1:0]        steps_q;
  logic [CODE_W-1:0]        act_q, sym_q;
  logic                     last_q, err_q;
  logic                     out_valid_q;

  logic [CODE_W-1:0]        mem [DEPTH];
  logic [DEPTH-1:0]         cell_valid_q;
  logic [CODE_W-1:0]        rd_data_q;
  logic                     rd_valid_q;

  logic [SIDE_W-1:0]        ex, ey;
  logic [9:0]               cells;
  logic signed [POS_W-1:0]  start_x, pos0_x, pos0_y;
  logic                     mark_open;
  logic [CODE_W-1:0]        mark_arrow, mark_dir, new_h, act_d, rd_sym;
  logic signed [POS_W-1:0]  nb_x, nb_y;
  logic                     mem_we, rd_en, out_load, cur_in, steps_out;
  logic [IDX_W-1:0]         waddr, raddr;
  logic [CODE_W-1:0]        wdata;

  always_comb begin
    ex      = eff_size(geom_i.size_x);
    ey      = eff_size(geom_i.size_y);
    cells   = 10'(ex) * 10'(ey);
    start_x = $signed(POS_W'(geom_i.start_col));
    pos0_x  = started_q ? robot_x_q : start_x;
    pos0_y  = started_q ? robot_y_q : '0;

    // Side neighbors in order right, left, front; each open one inside the grid gets an arrow back.
    case (mark_q)
      2'd0: begin
        mark_open  = item_q.open_r;
        mark_arrow = rot_cw(robot_h_q, 2'd3);
        mark_dir   = rot_cw(robot_h_q, 2'd1);
      end
      2'd1: begin
        mark_open  = item_q.open_l;
        mark_arrow = rot_cw(robot_h_q, 2'd1);
        mark_dir   = rot_cw(robot_h_q, 2'd3);
      end
      2'd2: begin
        mark_open  = item_q.open_f;
        mark_arrow = rot_cw(robot_h_q, 2'd2);
        mark_dir   = robot_h_q;
      end
      default: begin
        mark_open  = 1'b0;
        mark_arrow = robot_h_q;
        mark_dir   = robot_h_q;
      end
    endcase
    nb_x = step_x(mark_dir, robot_x_q);
    nb_y = step_y(mark_dir, robot_y_q);

    // Right-hand rule.
    if (item_q.open_r) begin
      act_d = mzp_pkg::ACT_RIGHT;
      new_h = rot_cw(robot_h_q, 2'd1);
    end else if (item_q.open_f) begin
      act_d = mzp_pkg::ACT_FWD;
      new_h = robot_h_q;
    end else if (item_q.open_l) begin
      act_d = mzp_pkg::ACT_LEFT;
      new_h = rot_cw(robot_h_q, 2'd3);
    end else begin
      act_d = mzp_pkg::ACT_TURN;
      new_h = rot_cw(robot_h_q, 2'd2);
    end

    cur_in    = in_grid(cur_x_q, cur_y_q, ex, ey);
    steps_out = 10'(steps_q) >= cells;
    rd_sym    = rd_valid_q ? rd_data_q : mzp_pkg::SYM_EMPTY;

    mem_we = 1'b0;
    waddr  = cell_idx(nb_x, nb_y, ex);
    wdata  = mark_arrow;
    if (state_q == S_MARK) begin
      mem_we = mark_open && in_grid(nb_x, nb_y, ex, ey);
    end else if (state_q == S_MOVE) begin
      mem_we = 1'b1;
      waddr  = cell_idx(robot_x_q, robot_y_q, ex);
      wdata  = new_h;
    end

    raddr = cell_idx(cur_x_q, cur_y_q, ex);
    rd_en = (state_q == S_READ) && cur_in && !steps_out;

    pop_o    = (state_q == S_IDLE) && head_i.valid;
    out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      mark_q       <= 2'd0;
      robot_x_q    <= '0;
      robot_y_q    <= '0;
      robot_h_q    <= mzp_pkg::H_UP;
      started_q    <= 1'b0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      active_q     <= 1'b0;
      steps_q      <= '0;
      act_q        <= mzp_pkg::ACT_NONE;
      sym_q        <= mzp_pkg::SYM_EMPTY;
      last_q       <= 1'b0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      cell_valid_q <= '0;
      rd_valid_q   <= 1'b0;
    end else begin
      if (mem_we) begin
        cell_valid_q[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= cell_valid_q[raddr];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            item_q <= head_i.item;
            act_q  <= mzp_pkg::ACT_NONE;
            sym_q  <= mzp_pkg::SYM_EMPTY;
            last_q <= 1'b0;
            err_q  <= 1'b0;
            if (head_i.item.cmd == mzp_pkg::CMD_EXPLORE) begin
              active_q <= 1'b0;
              if (!started_q) begin
                robot_x_q <= start_x;
                robot_y_q <= '0;
                robot_h_q <= mzp_pkg::H_UP;
                started_q <= 1'b1;
              end
              mark_q  <= 2'd0;
              state_q <= in_grid(pos0_x, pos0_y, ex, ey) ? S_MARK : S_EMIT;
            end else begin
              if (!active_q) begin
                cur_x_q  <= start_x;
                cur_y_q  <= '0;
                steps_q  <= '0;
                active_q <= 1'b1;
              end
              state_q <= S_READ;
            end
          end
        end
        S_MARK: begin
          mark_q <= mark_q + 2'd1;
          if (mark_q == 2'd2) begin
            state_q <= S_MOVE;
          end
        end
        S_MOVE: begin
          act_q     <= act_d;
          robot_h_q <= new_h;
          robot_x_q <= step_x(new_h, robot_x_q);
          robot_y_q <= step_y(new_h, robot_y_q);
          state_q   <= S_EMIT;
        end
        S_READ: begin
          if (!cur_in || steps_out) begin
            sym_q    <= mzp_pkg::SYM_END;
            last_q   <= 1'b1;
            err_q    <= cur_in;
            active_q <= 1'b0;
            state_q  <= S_EMIT;
          end else begin
            state_q <= S_RDATA;
          end
        end
        S_RDATA: begin
          sym_q   <= rd_sym;
          cur_x_q <= step_x(rd_sym, cur_x_q);
          cur_y_q <= step_y(rd_sym, cur_y_q);
          steps_q <= steps_q + STEP_W'(1);
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      action_o      <= act_q;
      heading_o     <= robot_h_q;
      pos_x_o       <= robot_x_q[mzp_pkg::OUT_POS_W-1:0];
      pos_y_o       <= robot_y_q[mzp_pkg::OUT_POS_W-1:0];
      exited_o      <= !in_grid(robot_x_q, robot_y_q, ex, ey);
      path_symbol_o <= sym_q;
      path_last_o   <= last_q;
      path_error_o  <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == S_IDLE) && head_i.valid)
    else $error("queue popped outside idle or while empty");

  a_write_only_explore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_MARK || state_q == S_MOVE))
    else $error("arrow memory written outside an explore step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> $stable(action_o) && $stable(path_symbol_o))
    else $error("waiting result overwritten");

  a_error_ends_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && err_q) |-> last_q && (sym_q == mzp_pkg::SYM_END))
    else $error("path error without end symbol");

  a_read_then_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> (state_q == S_RDATA))
    else $error("memory read not followed by data use");

endmodule

`default_nettype wire

// File: sv/grid_maze_explorer_path_map.sv
// Top level of the grid maze explorer with path map: configuration registers,
// the classifying front with its queue, and the executing back.
// Depends on mzp_pkg, mzp_front and mzp_back.
//
//   Channel  Direction  Handshake               Payload
//   config   in         cfg_we_i                cfg_idx_i, cfg_data_i
//   item     in         in_valid_i / in_stall_o cmd_i, dist_right_i, dist_front_i, dist_left_i
//   result   out        out_valid_o / out_stall_i action_o .. path_error_o
//
// An explore beat inside the grid passes through the back sequencer in order: the pop,
// one slot per side neighbor on the single write port of the arrow memory, the
// cell write with the move, and the hand-off to the result register. An explore
// beat outside the grid goes from the pop straight to the hand-off; a read beat adds
// a cursor check and, when it reads a cell, the registered memory read.
// Reset clears the position, heading and read-out state and the 81 per-cell valid
// bits at once, so the arrow memory reads as empty without a clearing pass.
// A two-beat queue keeps taking items while the back works or while a finished
// result waits under out_stall_i; in_stall_o rises only when the queue is full.
`default_nettype none

module grid_maze_explorer_path_map #(
  parameter int MAX_SIDE  = mzp_pkg::MAX_SIDE_DEF,
  parameter int DIST_BITS = mzp_pkg::DIST_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [1:0]                        cfg_idx_i,
  input  wire logic [mzp_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              cmd_i,
  input  wire logic [DIST_BITS-1:0]              dist_right_i,
  input  wire logic [DIST_BITS-1:0]              dist_front_i,
  input  wire logic [DIST_BITS-1:0]              dist_left_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [mzp_pkg::CODE_W-1:0]             action_o,
  output logic [mzp_pkg::CODE_W-1:0]             heading_o,
  output logic signed [mzp_pkg::OUT_POS_W-1:0]   pos_x_o,
  output logic signed [mzp_pkg::OUT_POS_W-1:0]   pos_y_o,
  output logic                                   exited_o,
  output logic [mzp_pkg::CODE_W-1:0]             path_symbol_o,
  output logic                                   path_last_o,
  output logic                                   path_error_o
);

  // Configuration registers. Writes must arrive only while the block is idle (the
  // block does not enforce this), so both halves may read them without any shadowing.
  logic [mzp_pkg::SIZE_W-1:0] size_x_q, size_y_q, start_col_q;
  logic [mzp_pkg::MIN_W-1:0]  min_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q    <= mzp_pkg::SIZE_X_RST;
      size_y_q    <= mzp_pkg::SIZE_Y_RST;
      start_col_q <= mzp_pkg::START_COL_RST;
      min_dist_q  <= mzp_pkg::MIN_DIST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mzp_pkg::CFG_SIZE_X:    size_x_q    <= cfg_data_i[mzp_pkg::SIZE_W-1:0];
        mzp_pkg::CFG_SIZE_Y:    size_y_q    <= cfg_data_i[mzp_pkg::SIZE_W-1:0];
        mzp_pkg::CFG_START_COL: start_col_q <= cfg_data_i[mzp_pkg::SIZE_W-1:0];
        mzp_pkg::CFG_MIN_DIST:  min_dist_q  <= cfg_data_i[mzp_pkg::MIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mzp_pkg::geom_t  geom;
  mzp_pkg::queue_t head;
  logic            pop;

  assign geom.size_x    = size_x_q;
  assign geom.size_y    = size_y_q;
  assign geom.start_col = start_col_q;

  // The front turns each distance into an open/closed flag at acceptance, so
  // the queue carries four bits per beat.
  mzp_front #(
    .DIST_BITS (DIST_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .min_dist_i   (min_dist_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .dist_right_i (dist_right_i),
    .dist_front_i (dist_front_i),
    .dist_left_i  (dist_left_i),
    .pop_i        (pop),
    .head_o       (head)
  );

  // The back owns the arrow memory, the robot and cursor state and the
  // result register.
  mzp_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .geom_i        (geom),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .heading_o     (heading_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .exited_o      (exited_o),
    .path_symbol_o (path_symbol_o),
    .path_last_o   (path_last_o),
    .path_error_o  (path_error_o)
  );

endmodule

`default_nettype wire

// File: dv/grid_maze_explorer_path_map_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of grid_maze_explorer_path_map: explore and read-out beats
// against a cycle-free model of the maze walker. Depends on mzp_pkg and the RTL only.
module grid_maze_explorer_path_map_test;
  import mzp_pkg::*;

  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int GRID_CELLS   = MAX_SIDE_DEF * MAX_SIDE_DEF;
  localparam int FULL_READOUT = GRID_CELLS + 2;

  // One result beat, fields in port order.
  typedef struct packed {
    logic [CODE_W-1:0]    action;
    logic [CODE_W-1:0]    heading;
    logic [OUT_POS_W-1:0] pos_x;
    logic [OUT_POS_W-1:0] pos_y;
    logic                 exited;
    logic [CODE_W-1:0]    path_symbol;
    logic                 path_last;
    logic                 path_error;
  } maze_result_t;

  typedef enum logic [1:0] {RD_IDLE, RD_RUN, RD_DONE} readout_phase_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [1:0]                  cfg_idx_i;
  logic [CFG_W-1:0]            cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        cmd_i;
  logic [DIST_BITS_DEF-1:0]    dist_right_i;
  logic [DIST_BITS_DEF-1:0]    dist_front_i;
  logic [DIST_BITS_DEF-1:0]    dist_left_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [CODE_W-1:0]           action_o;
  logic [CODE_W-1:0]           heading_o;
  logic signed [OUT_POS_W-1:0] pos_x_o;
  logic signed [OUT_POS_W-1:0] pos_y_o;
  logic                        exited_o;
  logic [CODE_W-1:0]           path_symbol_o;
  logic                        path_last_o;
  logic                        path_error_o;

  grid_maze_explorer_path_map DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .dist_right_i  (dist_right_i),
    .dist_front_i  (dist_front_i),
    .dist_left_i   (dist_left_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .heading_o     (heading_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .exited_o      (exited_o),
    .path_symbol_o (path_symbol_o),
    .path_last_o   (path_last_o),
    .path_error_o  (path_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Model state: a copy of the registers, the arrow map and the two walkers
  // (the robot that explores and the cursor that reads the path back).
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] cfg_size_x;
  logic [SIZE_W-1:0] cfg_size_y;
  logic [SIZE_W-1:0] cfg_start_col;
  logic [MIN_W-1:0]  cfg_min_dist;

  logic [CODE_W-1:0] arrow_map [GRID_CELLS];
  int                bot_x;
  int                bot_y;
  logic [CODE_W-1:0] bot_heading;
  bit                explore_started;
  int                cur_x;
  int                cur_y;
  readout_phase_t    rd_phase;
  int                rd_steps;

  maze_result_t maze_results_q [$];
  maze_result_t last_prediction;

  int send_idle_pct;
  int recv_stall_pct;
  int cycle_count;
  int error_count;
  int results_checked;
  int beat_count;
  int explore_beats;
  int read_beats;
  int readouts_done;
  int readouts_failed;
  int stuck_explores;

  // A register of 0 acts as one column or row, anything above the maximum as the maximum.
  function automatic int eff_side(logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return int'(v);
  endfunction

  function automatic bit cell_inside(int x, int y);
    return x >= 0 && y >= 0 && x < eff_side(cfg_size_x) && y < eff_side(cfg_size_y);
  endfunction

  function automatic int cell_addr(int x, int y);
    return x + y * eff_side(cfg_size_x);
  endfunction

  function automatic logic [CODE_W-1:0] turn_cw(logic [CODE_W-1:0] h, int quarters);
    return CODE_W'(((int'(h) - 1 + quarters) & 3) + 1);
  endfunction

  function automatic int dir_dx(logic [CODE_W-1:0] h);
    case (h)
      H_RIGHT: return 1;
      H_LEFT:  return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int dir_dy(logic [CODE_W-1:0] h);
    case (h)
      H_UP:    return 1;
      H_DOWN:  return -1;
      default: return 0;
    endcase
  endfunction

  // The neighbor lying opposite to the arrow gets that arrow, so it points back here.
  function automatic void mark_back(logic [CODE_W-1:0] arrow);
    int x, y;
    x = bot_x + dir_dx(turn_cw(arrow, 2));
    y = bot_y + dir_dy(turn_cw(arrow, 2));
    if (cell_inside(x, y)) arrow_map[cell_addr(x, y)] = arrow;
  endfunction

  function automatic maze_result_t predict_maze_step(logic cmd, logic [7:0] dr,
                                                     logic [7:0] df, logic [7:0] dl);
    maze_result_t res;
    logic [CODE_W-1:0] arrow;
    bit open_r, open_f, open_l;
    res.action      = ACT_NONE;
    res.path_symbol = SYM_EMPTY;
    res.path_last   = 1'b0;
    res.path_error  = 1'b0;
    if (cmd == CMD_EXPLORE) begin
      open_r = dr > cfg_min_dist;
      open_f = df > cfg_min_dist;
      open_l = dl > cfg_min_dist;
      // Any explore cancels a read-out in progress.
      rd_phase = RD_IDLE;
      if (!explore_started) begin
        bot_x           = int'(cfg_start_col);
        bot_y           = 0;
        bot_heading     = H_UP;
        explore_started = 1'b1;
      end
      if (cell_inside(bot_x, bot_y)) begin
        if (open_r) mark_back(turn_cw(bot_heading, 3));
        if (open_l) mark_back(turn_cw(bot_heading, 1));
        if (open_f) mark_back(turn_cw(bot_heading, 2));
        if (open_r) begin
          res.action  = ACT_RIGHT;
          bot_heading = turn_cw(bot_heading, 1);
        end else if (open_f) begin
          res.action  = ACT_FWD;
        end else if (open_l) begin
          res.action  = ACT_LEFT;
          bot_heading = turn_cw(bot_heading, 3);
        end else begin
          res.action  = ACT_TURN;
          bot_heading = turn_cw(bot_heading, 2);
        end
        arrow_map[cell_addr(bot_x, bot_y)] = bot_heading;
        bot_x = bot_x + dir_dx(bot_heading);
        bot_y = bot_y + dir_dy(bot_heading);
      end
    end else begin
      if (rd_phase != RD_RUN) begin
        cur_x    = int'(cfg_start_col);
        cur_y    = 0;
        rd_steps = 0;
        rd_phase = RD_RUN;
      end
      if (!cell_inside(cur_x, cur_y)) begin
        res.path_symbol = SYM_END;
        res.path_last   = 1'b1;
        rd_phase        = RD_DONE;
      end else if (rd_steps >= eff_side(cfg_size_x) * eff_side(cfg_size_y)) begin
        // Empty cell or a loop: the cursor never left the grid.
        res.path_symbol = SYM_END;
        res.path_last   = 1'b1;
        res.path_error  = 1'b1;
        rd_phase        = RD_DONE;
      end else begin
        arrow           = arrow_map[cell_addr(cur_x, cur_y)];
        res.path_symbol = arrow;
        cur_x           = cur_x + dir_dx(arrow);
        cur_y           = cur_y + dir_dy(arrow);
        rd_steps++;
      end
    end
    res.heading = bot_heading;
    res.pos_x   = bot_x[OUT_POS_W-1:0];
    res.pos_y   = bot_y[OUT_POS_W-1:0];
    res.exited  = !cell_inside(bot_x, bot_y);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item side. Inputs change on the falling edge; a beat is taken at a rising
  // edge with valid high and stall low, and only then enters the model.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic cmd, input logic [7:0] dr, input logic [7:0] df,
                           input logic [7:0] dl);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    cmd_i        = cmd;
    dist_right_i = dr;
    dist_front_i = df;
    dist_left_i  = dl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    last_prediction = predict_maze_step(cmd, dr, df, dl);
    maze_results_q.push_back(last_prediction);
    beat_count++;
    if (cmd == CMD_EXPLORE) begin
      explore_beats++;
      if (last_prediction.action == ACT_NONE) stuck_explores++;
    end else begin
      read_beats++;
      if (last_prediction.path_last) readouts_done++;
      if (last_prediction.path_error) readouts_failed++;
    end
  endtask

  // Hold off the item side until every expected result has been taken.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (maze_results_q.size() != 0) @(negedge clk_i);
  endtask

  // Only called while the block is idle, so the model may take the value at once.
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    case (idx)
      CFG_SIZE_X:    cfg_size_x    = value[SIZE_W-1:0];
      CFG_SIZE_Y:    cfg_size_y    = value[SIZE_W-1:0];
      CFG_START_COL: cfg_start_col = value[SIZE_W-1:0];
      default:       cfg_min_dist  = value;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Open means strictly above the threshold; the threshold itself is the hardest closed case.
  function automatic logic [7:0] pick_distance(bit want_open);
    if (want_open && cfg_min_dist != 8'hFF) begin
      if ($urandom_range(0, 7) == 0) return cfg_min_dist + 8'd1;
      return 8'($urandom_range(int'(cfg_min_dist) + 1, 255));
    end
    if ($urandom_range(0, 7) == 0) return cfg_min_dist;
    return 8'($urandom_range(0, int'(cfg_min_dist)));
  endfunction

  function automatic bit side_inside(int quarters);
    logic [CODE_W-1:0] h;
    h = turn_cw(bot_heading, quarters);
    return cell_inside(bot_x + dir_dx(h), bot_y + dir_dy(h));
  endfunction

  // A walk keeps the robot in the grid unless it runs wild: sides that lead out
  // are mostly reported closed, and a dead end with no way back gets one exit.
  task automatic walk_maze(input int steps, input bit wild);
    bit want_r, want_f, want_l;
    bit in_r, in_f, in_l, in_b;
    for (int i = 0; i < steps; i++) begin
      in_r   = side_inside(1);
      in_f   = side_inside(0);
      in_l   = side_inside(3);
      in_b   = side_inside(2);
      want_r = 1'($urandom_range(0, 1));
      want_f = 1'($urandom_range(0, 1));
      want_l = 1'($urandom_range(0, 1));
      if (!wild) begin
        want_r = want_r && in_r;
        want_f = want_f && in_f;
        want_l = want_l && in_l;
        if (!want_r && !want_f && !want_l && !in_b) begin
          if (in_r) want_r = 1'b1;
          else if (in_f) want_f = 1'b1;
          else want_l = 1'b1;
        end
      end
      send_beat(CMD_EXPLORE, pick_distance(want_r), pick_distance(want_f),
                pick_distance(want_l));
    end
  endtask

  // Read symbols until the path ends or the given number of beats has gone out.
  task automatic run_readout(input int max_symbols);
    int n = 0;
    do begin
      send_beat(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom));
      n++;
    end while (!last_prediction.path_last && n < max_symbols);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, and every taken beat against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch on result %0d: expected %0d, actual %0d",
               $time, field, results_checked, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    maze_result_t seen;
    maze_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {action_o, heading_o, pos_x_o, pos_y_o, exited_o,
              path_symbol_o, path_last_o, path_error_o};
      if (maze_results_q.size() == 0) begin
        error_count++;
        $display("%0t: result beat with nothing expected: expected none, actual %h",
                 $time, seen);
      end else begin
        want = maze_results_q.pop_front();
        check_field("action", int'(want.action), int'(seen.action));
        check_field("heading", int'(want.heading), int'(seen.heading));
        check_field("pos_x", int'($signed(want.pos_x)), int'($signed(seen.pos_x)));
        check_field("pos_y", int'($signed(want.pos_y)), int'($signed(seen.pos_y)));
        check_field("exited", int'(want.exited), int'(seen.exited));
        check_field("path_symbol", int'(want.path_symbol), int'(seen.path_symbol));
        check_field("path_last", int'(want.path_last), int'(seen.path_last));
        check_field("path_error", int'(want.path_error), int'(seen.path_error));
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d results outstanding",
               $time, cycle_count, maze_results_q.size());
      $display("** grid_maze_explorer_path_map: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Reads over a map with no arrows: an empty cell ends in an error after one
  // pass over the grid, and an entry column outside the grid ends at once.
  task automatic test_empty_readout();
    send_beat(CMD_READ, 8'h00, 8'h00, 8'h00);
    wait_idle();
    write_reg(CFG_SIZE_X, 8'h00);
    write_reg(CFG_SIZE_Y, 8'h00);
    send_beat(CMD_READ, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_READ, 8'h00, 8'h00, 8'h00);
    send_beat(CMD_READ, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();
    write_reg(CFG_START_COL, 8'h0F);
    send_beat(CMD_READ, 8'h00, 8'h00, 8'h00);
    send_beat(CMD_READ, 8'h00, 8'h00, 8'h00);
  endtask

  // The first explore loads the entry cell; here it lies outside, so the robot
  // has exited from the start and does nothing.
  task automatic test_entry_outside();
    wait_idle();
    write_reg(CFG_SIZE_X, 8'h05);
    write_reg(CFG_SIZE_Y, 8'h04);
    write_reg(CFG_START_COL, 8'h07);
    send_beat(CMD_EXPLORE, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_READ, 8'h00, 8'h00, 8'h00);
  endtask

  // Widening the grid brings the robot in; then each branch of the right-hand
  // rule, distances right at the threshold, an explore that cuts a read-out
  // short, and both extreme thresholds.
  task automatic test_turn_rules();
    wait_idle();
    write_reg(CFG_SIZE_X, 8'h0F);
    write_reg(CFG_SIZE_Y, 8'h09);
    write_reg(CFG_MIN_DIST, 8'd22);
    send_beat(CMD_EXPLORE, 8'd22, 8'd23, 8'hFF);
    send_beat(CMD_EXPLORE, 8'd0, 8'd0, 8'd23);
    send_beat(CMD_EXPLORE, 8'd22, 8'd22, 8'd22);
    send_beat(CMD_EXPLORE, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_READ, 8'h00, 8'h00, 8'h00);
    send_beat(CMD_READ, 8'h00, 8'h00, 8'h00);
    send_beat(CMD_EXPLORE, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_READ, 8'h00, 8'h00, 8'h00);
    wait_idle();
    write_reg(CFG_MIN_DIST, 8'd0);
    send_beat(CMD_EXPLORE, 8'd0, 8'd0, 8'd0);
    send_beat(CMD_EXPLORE, 8'd1, 8'd0, 8'd0);
    wait_idle();
    write_reg(CFG_MIN_DIST, 8'hFF);
    send_beat(CMD_EXPLORE, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // Shrinking the grid leaves the robot outside, and an explore then does nothing.
  task automatic test_exit_by_resize();
    wait_idle();
    write_reg(CFG_SIZE_X, 8'h01);
    send_beat(CMD_EXPLORE, 8'hFF, 8'hFF, 8'hFF);
    send_beat(CMD_READ, 8'h00, 8'h00, 8'h00);
    wait_idle();
    write_reg(CFG_SIZE_X, 8'h09);
    write_reg(CFG_MIN_DIST, 8'd22);
  endtask

  // ---------------------------------------------------------------------------
  // Random rounds: new registers, a walk, sometimes a read-out broken by an
  // explore, then a full read-out; noise items only near the end, since a robot
  // that walks off the low edge never comes back.
  // ---------------------------------------------------------------------------
  function automatic logic [SIZE_W-1:0] pick_side(int pos);
    int lo;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 4'd0;
        1:       return 4'd1;
        2:       return 4'd9;
        default: return 4'd15;
      endcase
    end
    lo = (pos >= 0) ? pos + 1 : 1;
    if (lo > MAX_SIDE_DEF) lo = MAX_SIDE_DEF;
    return SIZE_W'($urandom_range(lo, (lo + 2 > MAX_SIDE_DEF) ? MAX_SIDE_DEF : lo + 2));
  endfunction

  task automatic configure_random();
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sc;
    logic [MIN_W-1:0]  md;
    sx = pick_side(bot_x);
    sy = pick_side(bot_y);
    case ($urandom_range(0, 15))
      0:       sc = 4'd0;
      1:       sc = 4'd8;
      2:       sc = 4'd15;
      default: sc = SIZE_W'($urandom_range(0, eff_side(sx) - 1));
    endcase
    case ($urandom_range(0, 15))
      0:       md = 8'd0;
      1:       md = 8'hFF;
      default: md = 8'($urandom_range(5, 200));
    endcase
    // The 4-bit registers get random upper data bits, which the block drops.
    write_reg(CFG_SIZE_X, {4'($urandom), sx});
    write_reg(CFG_SIZE_Y, {4'($urandom), sy});
    write_reg(CFG_START_COL, {4'($urandom), sc});
    write_reg(CFG_MIN_DIST, md);
  endtask

  task automatic test_random_walks(input int first_beat);
    int round = 0;
    bit wild;
    while (beat_count - first_beat < RANDOM_ITEMS) begin
      case (round % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      wild = (beat_count - first_beat) > RANDOM_ITEMS * 85 / 100;
      wait_idle();
      configure_random();
      walk_maze($urandom_range(4, 16), wild);
      if (round % 7 == 3) begin
        // Let the block run dry in the middle of a walk.
        wait_idle();
        walk_maze($urandom_range(2, 6), wild);
      end
      if ($urandom_range(0, 2) == 0) begin
        run_readout($urandom_range(1, 3));
        walk_maze($urandom_range(1, 3), wild);
      end
      run_readout(FULL_READOUT);
      if ($urandom_range(0, 3) == 0) run_readout(FULL_READOUT);
      if (wild) begin
        repeat ($urandom_range(2, 6)) begin
          send_beat(1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      round++;
    end
  endtask

  initial begin
    int first_random;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_SIZE_X;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    cmd_i           = CMD_EXPLORE;
    dist_right_i    = '0;
    dist_front_i    = '0;
    dist_left_i     = '0;
    out_stall_i     = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    cycle_count     = 0;
    error_count     = 0;
    results_checked = 0;
    beat_count      = 0;
    explore_beats   = 0;
    read_beats      = 0;
    readouts_done   = 0;
    readouts_failed = 0;
    stuck_explores  = 0;
    cfg_size_x      = SIZE_X_RST;
    cfg_size_y      = SIZE_Y_RST;
    cfg_start_col   = START_COL_RST;
    cfg_min_dist    = MIN_DIST_RST;
    foreach (arrow_map[i]) arrow_map[i] = SYM_EMPTY;
    bot_x           = 0;
    bot_y           = 0;
    bot_heading     = H_UP;
    explore_started = 1'b0;
    cur_x           = 0;
    cur_y           = 0;
    rd_phase        = RD_IDLE;
    rd_steps        = 0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_readout();
    test_entry_outside();
    test_turn_rules();
    test_exit_by_resize();
    first_random = beat_count;
    test_random_walks(first_random);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d explore and %0d read beats; %0d read-outs ended, %0d on a loop %s",
             explore_beats, read_beats, readouts_done, readouts_failed, "or empty cell.");
    $display("%0d explores found the robot outside the grid; %0d results checked, %0d mismatches.",
             stuck_explores, results_checked, error_count);
    if (error_count == 0) begin
      $display("** grid_maze_explorer_path_map: PASSED **");
    end else begin
      $display("** grid_maze_explorer_path_map: FAILED **");
    end
    $finish;
  end

endmodule
